// File: design/gost_block_cipher_with_key_meshing_macros.svh
// Assertion macros shared by the cipher RTL.
// Needs a clock named clk and an active-low reset named arst_n in the including module.
`ifndef GOST_BLOCK_CIPHER_WITH_KEY_MESHING_MACROS_SVH
`define GOST_BLOCK_CIPHER_WITH_KEY_MESHING_MACROS_SVH
`ifndef ASSERT_OFF
`define GBC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define GBC_ASSERT_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define GBC_ASSERT(name, prop, msg)
`define GBC_ASSERT_NEVER(name, expr, msg)
`endif
`endif

// File: design/gbc_pkg.sv
// Types, constants and helper functions of the block cipher with key meshing.
// Used by the substitution RAM and by the top level; depends on nothing.
`default_nettype none

package gbc_pkg;

	localparam int WORD_W            = 32;
	localparam int LANES             = 4;
	localparam int LANE_DEPTH        = 256;
	localparam int LANE_AW           = $clog2(LANE_DEPTH);
	localparam int KEY_WORDS         = 8;
	localparam int KEY_AW            = $clog2(KEY_WORDS);
	localparam int ROUND_W           = 5;
	localparam int PASS_W            = 3;
	localparam int COUNT_W           = 11;
	localparam int MESH_INTERVAL_DEF = 1024;
	localparam int FRESH_WORDS       = 6;

	localparam logic [ROUND_W-1:0] ROUND_LAST     = 5'd31;
	localparam logic [PASS_W-1:0]  PASS_MESH_LAST = 3'd3;
	localparam logic [PASS_W-1:0]  PASS_FIRST_ENC = 3'd4;
	localparam logic [PASS_W-1:0]  PASS_FINAL     = 3'd5;
	localparam logic [COUNT_W-1:0] COUNT_STEP     = 11'd8;

	// Meshing key, read as little-endian 32-bit words.
	localparam logic [KEY_WORDS-1:0][WORD_W-1:0] MESH_KEY = {
		32'h2BA94CEF, 32'hC2DC86C0, 32'h1207ED00, 32'h94ACFE18,
		32'hC42AE946, 32'h96DB3A8D, 32'h2304C964, 32'h22720069
	};

	typedef enum logic [1:0] {
		OP_TABLE = 2'd0,
		OP_KEY   = 2'd1,
		OP_ENC   = 2'd2,
		OP_DEC   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_ROUND,
		ST_FINISH
	} state_t;

	// Encryption runs the key forward three times and backward once;
	// decryption runs it forward once and backward three times.
	function automatic logic [KEY_AW-1:0] key_sel(input logic [ROUND_W-1:0] rnd,
			input logic dec);
		logic flip;
		if (dec) begin
			flip = (rnd[4:3] != 2'd0);
		end else begin
			flip = (rnd[4:3] == 2'd3);
		end
		return flip ? ~rnd[2:0] : rnd[2:0];
	endfunction

endpackage

`default_nettype wire

// File: design/gbc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Uses gbc_pkg for default sizes.
`default_nettype none

module gbc_ram #(
	parameter int WIDTH = gbc_pkg::WORD_W,
	parameter int DEPTH = gbc_pkg::LANE_DEPTH
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);
	import gbc_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// File: design/gost_block_cipher_with_key_meshing.sv
// Top level of the 64-bit Feistel block cipher with key meshing.
// Depends on gbc_pkg, gbc_ram and the assertion macro header.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    op, index, load_value, block_first, block_second
// out       output     out_valid / out_ready  result_first, result_second
// cfg       input      cfg_wr_en              cfg_wr_data (mesh enable)
//
// Table and key loads produce no item.
// An encrypt or decrypt runs from acceptance through a setup state, then one round per cycle
// through the four lanes of the substitution RAM, then a finish state, into the output register.
// A meshing encrypt runs six such passes.
// Reset clears only control state; table and key contents are undefined until loaded.
// A held output item stalls the finish of the next item, not its acceptance.
`default_nettype none
`include "gost_block_cipher_with_key_meshing_macros.svh"

module gost_block_cipher_with_key_meshing #(
	parameter int MESH_INTERVAL_BYTES = gbc_pkg::MESH_INTERVAL_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [9:0]  index,
	input  wire logic [31:0] load_value,
	input  wire logic [31:0] block_first,
	input  wire logic [31:0] block_second,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [31:0] result_first,
	output      logic [31:0] result_second
);
	import gbc_pkg::*;

	state_t               state_q, state_d;
	logic [ROUND_W-1:0]   round_q;
	logic [PASS_W-1:0]    pass_q;
	logic                 mesh_q;
	logic                 dec_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 mesh_enable_q;
	logic                 out_valid_q;

	logic [WORD_W-1:0]    a_q, b_q;
	logic [WORD_W-1:0]    blk_first_q, blk_second_q;
	logic [WORD_W-1:0]    key_q [KEY_WORDS];
	logic [WORD_W-1:0]    fresh_q [FRESH_WORDS];
	logic [WORD_W-1:0]    result_first_q, result_second_q;

	logic                 accept;
	logic                 is_crypt;
	logic                 key_load;
	logic                 mesh_go;
	logic                 last_pass;
	logic                 dec_pass;
	logic                 out_free;
	logic [LANES-1:0]     tbl_we;
	logic [WORD_W-1:0]    rd_word [LANES];
	logic [WORD_W-1:0]    f_word;
	logic [WORD_W-1:0]    new_half;
	logic [WORD_W-1:0]    feed;
	logic [WORD_W-1:0]    round_key;
	logic [WORD_W-1:0]    sum;
	logic [ROUND_W-1:0]   round_next;
	logic [1:0]           pair_next;

	assign accept    = in_valid && in_ready;
	assign is_crypt  = (op_t'(op) == OP_ENC) || (op_t'(op) == OP_DEC);
	assign key_load  = accept && (op_t'(op) == OP_KEY) && (index[9:KEY_AW] == '0);
	assign mesh_go   = mesh_enable_q && (count_q == COUNT_W'(MESH_INTERVAL_BYTES));
	assign last_pass = !mesh_q || (pass_q == PASS_FINAL);
	assign dec_pass  = mesh_q ? (pass_q <= PASS_MESH_LAST) : dec_q;
	assign out_free  = !out_valid_q || out_ready;
	assign f_word    = rd_word[0] | rd_word[1] | rd_word[2] | rd_word[3];
	assign new_half  = b_q ^ f_word;
	assign round_next = round_q + 5'd1;
	assign pair_next = pass_q[1:0] + 2'd1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && is_crypt) begin
					state_d = ST_START;
				end
			end
			ST_START: state_d = ST_ROUND;
			ST_ROUND: begin
				if (round_q == ROUND_LAST) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!last_pass) begin
					state_d = ST_START;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		feed      = a_q;
		round_key = key_q[key_sel('0, dec_pass)];
		if (state_q == ST_ROUND) begin
			feed      = new_half;
			round_key = key_q[key_sel(round_next, dec_pass)];
		end
		sum = feed + round_key;
		for (int i = 0; i < LANES; i++) begin
			tbl_we[i] = accept && (op_t'(op) == OP_TABLE) && (index[9:LANE_AW] == 2'(i));
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		gbc_ram #(
			.WIDTH(WORD_W),
			.DEPTH(LANE_DEPTH)
		) u_lane (
			.clk    (clk),
			.wr_en  (tbl_we[g]),
			.wr_addr(index[LANE_AW-1:0]),
			.wr_data(load_value),
			.rd_addr(sum[g*LANE_AW +: LANE_AW]),
			.rd_data(rd_word[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			round_q       <= '0;
			pass_q        <= '0;
			mesh_q        <= 1'b0;
			dec_q         <= 1'b0;
			count_q       <= '0;
			mesh_enable_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				mesh_enable_q <= cfg_wr_data;
			end
			if (key_load) begin
				count_q <= '0;
			end
			if (accept && is_crypt) begin
				mesh_q <= (op_t'(op) == OP_ENC) && mesh_go;
				dec_q  <= (op_t'(op) == OP_DEC);
				pass_q <= '0;
				if (op_t'(op) == OP_ENC) begin
					count_q <= mesh_go ? COUNT_STEP : count_q + COUNT_STEP;
				end
			end
			if (state_q == ST_START) begin
				round_q <= '0;
			end else if (state_q == ST_ROUND) begin
				round_q <= round_next;
			end
			if (state_q == ST_FINISH && !last_pass) begin
				pass_q <= pass_q + 3'd1;
			end
			if (state_q == ST_FINISH && last_pass && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_load) begin
			key_q[index[KEY_AW-1:0]] <= load_value;
		end
		if (accept && is_crypt) begin
			blk_first_q  <= block_first;
			blk_second_q <= block_second;
			if (op_t'(op) == OP_ENC && mesh_go) begin
				a_q <= MESH_KEY[0];
				b_q <= MESH_KEY[1];
			end else begin
				a_q <= block_first;
				b_q <= block_second;
			end
		end
		if (state_q == ST_ROUND) begin
			a_q <= new_half;
			b_q <= a_q;
		end
		if (state_q == ST_FINISH && !last_pass) begin
			priority if (pass_q < PASS_MESH_LAST) begin
				fresh_q[{pass_q[1:0], 1'b0}] <= b_q;
				fresh_q[{pass_q[1:0], 1'b1}] <= a_q;
				a_q <= MESH_KEY[{pair_next, 1'b0}];
				b_q <= MESH_KEY[{pair_next, 1'b1}];
			end else if (pass_q == PASS_MESH_LAST) begin
				for (int i = 0; i < FRESH_WORDS; i++) begin
					key_q[i] <= fresh_q[i];
				end
				key_q[KEY_WORDS-2] <= b_q;
				key_q[KEY_WORDS-1] <= a_q;
				a_q <= blk_first_q;
				b_q <= blk_second_q;
			end else begin
				a_q <= b_q;
				b_q <= a_q;
			end
		end
		if (state_q == ST_FINISH && last_pass && out_free) begin
			result_first_q  <= b_q;
			result_second_q <= a_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_first  = result_first_q;
	assign result_second = result_second_q;

	`GBC_ASSERT(a_start_to_round, (state_q == ST_START) |=> (state_q == ST_ROUND && round_q == '0), "Round counter did not restart with a pass")
	`GBC_ASSERT_NEVER(a_pass_range, pass_q > PASS_FINAL, "Pass counter ran past the last meshing pass")
	`GBC_ASSERT(a_plain_single_pass, (!mesh_q && state_q != ST_IDLE) |-> (pass_q == '0), "Plain item ran more than one pass")
	`GBC_ASSERT(a_key_load_clears, key_load |=> (count_q == '0), "Key load did not clear the byte counter")
	`GBC_ASSERT(a_table_write_idle, (|tbl_we) |-> (state_q == ST_IDLE && $onehot(tbl_we)), "Table written outside idle or in several lanes")

endmodule

`default_nettype wire

// File: bench/tb_gost_block_cipher_with_key_meshing.sv
// Testbench for the 64-bit Feistel block cipher with key meshing: loads tables and keys,
// then checks every encrypt and decrypt item against its own cycle-free cipher model.
// Depends on gbc_pkg and the gost_block_cipher_with_key_meshing top level only.
module tb_gost_block_cipher_with_key_meshing;
	timeunit 1ns;
	timeprecision 1ps;

	import gbc_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 250;
	localparam logic [10:0] MESH_POINT = 11'd1024;
	localparam logic [0:31][7:0] MESH_BYTES = {
		8'h69, 8'h00, 8'h72, 8'h22, 8'h64, 8'hC9, 8'h04, 8'h23,
		8'h8D, 8'h3A, 8'hDB, 8'h96, 8'h46, 8'hE9, 8'h2A, 8'hC4,
		8'h18, 8'hFE, 8'hAC, 8'h94, 8'h00, 8'hED, 8'h07, 8'h12,
		8'hC0, 8'h86, 8'hDC, 8'hC2, 8'hEF, 8'h4C, 8'hA9, 8'h2B
	};

	typedef struct {
		op_t         opc;
		logic [9:0]  idx;
		logic [31:0] word;
		logic [31:0] half1;
		logic [31:0] half2;
	} cipher_cmd_t;

	typedef struct {
		logic [31:0] lo;
		logic [31:0] hi;
	} block_pair_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	op_t         op = OP_TABLE;
	logic [9:0]  index = '0;
	logic [31:0] load_value = '0;
	logic [31:0] block_first = '0;
	logic [31:0] block_second = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] result_first;
	logic [31:0] result_second;

	cipher_cmd_t pending_q[$];
	block_pair_t cipher_out_q[$];
	cipher_cmd_t next_cmd;
	block_pair_t got_pair;
	block_pair_t want_pair;
	logic        in_taken = 1'b0;
	logic        quiet = 1'b0;
	int          mismatch_count = 0;
	int          cycle_count = 0;

	logic [31:0] sbox_mem [1024];
	logic [31:0] key_mem [8];
	logic [10:0] byte_count = '0;
	logic        mesh_on = 1'b0;

	gost_block_cipher_with_key_meshing dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.index(index),
		.load_value(load_value),
		.block_first(block_first),
		.block_second(block_second),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_first(result_first),
		.result_second(result_second)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic [31:0] feistel_f(input logic [31:0] k, input logic [31:0] half);
		logic [31:0] s;
		s = half + k;
		return sbox_mem[{2'd0, s[7:0]}] | sbox_mem[{2'd1, s[15:8]}] |
			sbox_mem[{2'd2, s[23:16]}] | sbox_mem[{2'd3, s[31:24]}];
	endfunction

	function automatic void run_rounds(input bit backward, input logic [31:0] a_in,
			input logic [31:0] b_in, output logic [31:0] first, output logic [31:0] second);
		logic [31:0] n1;
		logic [31:0] n2;
		int          low;
		int          ki;
		n1 = a_in;
		n2 = b_in;
		for (int r = 0; r < 32; r++) begin
			low = r % 8;
			if (backward) begin
				ki = (r < 8) ? low : 7 - low;
			end else begin
				ki = (r < 24) ? low : 7 - low;
			end
			if (r % 2 == 0) begin
				n2 = n2 ^ feistel_f(key_mem[ki], n1);
			end else begin
				n1 = n1 ^ feistel_f(key_mem[ki], n2);
			end
		end
		first = n2;
		second = n1;
	endfunction

	function automatic void remesh_keys();
		logic [31:0] fresh [8];
		logic [31:0] w1;
		logic [31:0] w2;
		for (int i = 0; i < 4; i++) begin
			w1 = {MESH_BYTES[8*i+3], MESH_BYTES[8*i+2], MESH_BYTES[8*i+1], MESH_BYTES[8*i]};
			w2 = {MESH_BYTES[8*i+7], MESH_BYTES[8*i+6], MESH_BYTES[8*i+5], MESH_BYTES[8*i+4]};
			run_rounds(1'b1, w1, w2, fresh[2*i], fresh[2*i+1]);
		end
		for (int i = 0; i < 8; i++) begin
			key_mem[i] = fresh[i];
		end
		byte_count = '0;
	endfunction

	function automatic void gost_apply(input op_t o, input logic [9:0] i,
			input logic [31:0] w, input logic [31:0] h1, input logic [31:0] h2);
		logic [31:0] a;
		logic [31:0] b;
		block_pair_t res;
		a = h1;
		b = h2;
		case (o)
			OP_TABLE: begin
				sbox_mem[i] = w;
			end
			OP_KEY: begin
				if (i < 10'd8) begin
					key_mem[i[2:0]] = w;
					byte_count = '0;
				end
			end
			OP_ENC: begin
				if (mesh_on && byte_count == MESH_POINT) begin
					remesh_keys();
					run_rounds(1'b0, h1, h2, a, b);
				end
				run_rounds(1'b0, a, b, res.lo, res.hi);
				byte_count = byte_count + 11'd8;
				cipher_out_q.push_back(res);
			end
			default: begin
				run_rounds(1'b1, a, b, res.lo, res.hi);
				cipher_out_q.push_back(res);
			end
		endcase
	endfunction

	// A table entry shaped like a real expanded S-box: one byte in its lane, rotated by 11.
	function automatic logic [31:0] lane_word(input int lane);
		logic [31:0] w;
		w = {24'd0, 8'($urandom_range(0, 255))} << (8 * lane);
		return {w[20:0], w[31:21]};
	endfunction

	function automatic void queue_cmd(input op_t o, input logic [9:0] i, input logic [31:0] w,
			input logic [31:0] h1, input logic [31:0] h2);
		cipher_cmd_t c;
		c.opc = o;
		c.idx = i;
		c.word = w;
		c.half1 = h1;
		c.half2 = h2;
		pending_q.push_back(c);
	endfunction

	function automatic void queue_random_cmd();
		int r;
		r = $urandom_range(0, 299);
		if (r == 0) begin
			queue_cmd(OP_KEY, 10'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
		end else if (r < 7) begin
			queue_cmd(OP_KEY, 10'($urandom_range(8, 1023)), $urandom, $urandom, $urandom);
		end else if (r < 16) begin
			queue_cmd(OP_TABLE, 10'($urandom_range(0, 1023)),
				(r < 13) ? lane_word($urandom_range(0, 3)) : $urandom, $urandom, $urandom);
		end else if (r < 76) begin
			queue_cmd(OP_DEC, 10'($urandom_range(0, 1023)), $urandom, $urandom, $urandom);
		end else begin
			queue_cmd(OP_ENC, 10'($urandom_range(0, 1023)), $urandom, $urandom, $urandom);
		end
	endfunction

	task automatic settle();
		while (pending_q.size() != 0 || in_valid || cipher_out_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mesh(input logic v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		mesh_on = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 11)) begin
					next_cmd = pending_q.pop_front();
					in_valid <= 1'b1;
					op <= next_cmd.opc;
					index <= next_cmd.idx;
					load_value <= next_cmd.word;
					block_first <= next_cmd.half1;
					block_second <= next_cmd.half2;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= quiet || $urandom_range(0, 99) >= 11;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_taken = in_valid && in_ready;
			if (in_taken) begin
				gost_apply(op, index, load_value, block_first, block_second);
			end
			if (out_valid && out_ready) begin
				got_pair.lo = result_first;
				got_pair.hi = result_second;
				if (cipher_out_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("unexpected result item %h %h", got_pair.lo, got_pair.hi);
					end
				end else begin
					want_pair = cipher_out_q.pop_front();
					if (got_pair.lo !== want_pair.lo || got_pair.hi !== want_pair.hi) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("result mismatch: expected %h %h, got %h %h",
								want_pair.lo, want_pair.hi, got_pair.lo, got_pair.hi);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_gost_block_cipher_with_key_meshing: errors");
			$finish;
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		write_mesh(1'b0);

		for (int i = 0; i < 1024; i++) begin
			queue_cmd(OP_TABLE, 10'(i), lane_word(i / 256), $urandom, $urandom);
		end
		for (int i = 0; i < 8; i++) begin
			queue_cmd(OP_KEY, 10'(i), $urandom, $urandom, $urandom);
		end

		queue_cmd(OP_TABLE, 10'd0, 32'h0000_0000, '0, '0);
		queue_cmd(OP_TABLE, 10'd1023, 32'hFFFF_FFFF, '1, '1);
		queue_cmd(OP_KEY, 10'd0, 32'h0000_0000, $urandom, $urandom);
		queue_cmd(OP_KEY, 10'd7, 32'hFFFF_FFFF, $urandom, $urandom);
		queue_cmd(OP_KEY, 10'd8, $urandom, $urandom, $urandom);
		queue_cmd(OP_KEY, 10'd1023, $urandom, $urandom, $urandom);
		queue_cmd(OP_ENC, 10'd0, 32'h0, 32'h0000_0000, 32'h0000_0000);
		queue_cmd(OP_ENC, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(OP_DEC, 10'd0, 32'h0, 32'h0000_0000, 32'h0000_0000);
		queue_cmd(OP_DEC, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(OP_ENC, 10'd5, $urandom, $urandom, $urandom);
		queue_cmd(OP_DEC, 10'd9, $urandom, $urandom, $urandom);
		queue_cmd(OP_TABLE, 10'd0, lane_word(0), $urandom, $urandom);
		queue_cmd(OP_TABLE, 10'd1023, lane_word(3), $urandom, $urandom);
		queue_cmd(OP_KEY, 10'd0, $urandom, $urandom, $urandom);
		queue_cmd(OP_KEY, 10'd7, $urandom, $urandom, $urandom);
		queue_cmd(OP_ENC, 10'd0, $urandom, $urandom, $urandom);
		queue_cmd(OP_DEC, 10'd0, $urandom, $urandom, $urandom);
		settle();

		write_mesh(1'b1);
		for (int i = 0; i < 220; i++) begin
			queue_random_cmd();
		end
		settle();

		write_mesh(1'b0);
		quiet = 1'b1;
		for (int i = 0; i < 80; i++) begin
			queue_random_cmd();
		end
		settle();
		quiet = 1'b0;

		write_mesh(1'b1);
		for (int i = 0; i < 100; i++) begin
			queue_random_cmd();
		end
		settle();

		if (mismatch_count == 0 && cipher_out_q.size() == 0) begin
			$display("tb_gost_block_cipher_with_key_meshing: clean");
		end else begin
			$display("tb_gost_block_cipher_with_key_meshing: errors");
		end
		$finish;
	end

endmodule
